FILE: hdl/mfd_pkg.sv
// package for the motor feedback multi-turn decoder
// payload structs, divider control structs, state codes and constants
// no dependencies
`default_nettype none

package mfd_pkg;

    localparam int CprWidth = 17;
    localparam int GearWidth = 8;
    localparam int CfgDataWidth = 17;
    localparam int CfgIndexWidth = 1;
    localparam int DeltaWidth = 19;
    localparam int ProdWidth = 44;
    localparam int DivSteps = ProdWidth / 2;
    localparam int DivCntWidth = $clog2(DivSteps);

    localparam logic [CprWidth-1:0] CprReset = 17'd8192;
    localparam logic [GearWidth-1:0] GearReset = 8'd19;
    localparam logic [ProdWidth-1:0] AngleScale = 44'd2880;

    localparam logic [CfgIndexWidth-1:0] CfgCountsPerRev = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgGearRatio = 1'b1;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [7:0] byte7;
    } mfd_in_t;

    typedef struct packed {
        logic [15:0]        raw_position;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] torque_current;
        logic [7:0]         fault_code;
        logic signed [31:0] position_total;
        logic signed [47:0] angle_q16;
        logic signed [31:0] shaft_speed_q16;
    } mfd_out_t;

    typedef struct packed {
        logic                 start;
        logic [ProdWidth-1:0] dividend;
        logic [GearWidth-1:0] divisor;
    } mfd_div_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [ProdWidth-1:0] quotient;
    } mfd_div_stat_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_WRAP   = 9'b000000010,
        S_ACCUM  = 9'b000000100,
        S_MUL    = 9'b000001000,
        S_ANG_ST = 9'b000010000,
        S_ANG_WT = 9'b000100000,
        S_SPD_ST = 9'b001000000,
        S_SPD_WT = 9'b010000000,
        S_DONE   = 9'b100000000
    } mfd_state_t;

endpackage

`default_nettype wire

FILE: hdl/mfd_div.sv
// shared unsigned serial divider, two quotient bits per cycle
// depends on mfd_pkg
`default_nettype none

module mfd_div
    import mfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mfd_div_ctl_t  ctl,
    output mfd_div_stat_t      stat
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DivCntWidth-1:0] cnt_reg, cnt_next;
    logic [ProdWidth-1:0]   quo_reg, quo_next;
    logic [GearWidth-1:0]   rem_reg, rem_next;
    logic [GearWidth-1:0]   div_reg, div_next;

    logic [ProdWidth-1:0]   q_step;
    logic [GearWidth-1:0]   r_step;
    logic [GearWidth:0]     trial;

    // two restoring steps per cycle
    always_comb
    begin
        q_step = quo_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial  = {r_step, q_step[ProdWidth-1]};
            q_step = {q_step[ProdWidth-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                r_step    = GearWidth'(trial - {1'b0, div_reg});
                q_step[0] = 1'b1;
            end
            else
            begin
                r_step = trial[GearWidth-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = ctl.dividend;
            rem_next  = '0;
            div_next  = ctl.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DivCntWidth'(DivSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/motor_feedback_multiturn_decoder.sv
// motor feedback decoder: frame unpack, multi-turn unwrap, angle and speed scaling
// one frame at a time: a new frame is taken only once the sequencer is back in idle, after
// the last result is registered; each frame runs two passes of the shared divider
// (two quotient bits per cycle)
// reset: async active low; clears the sequencer, multi-turn state and output valid, and restores the config registers
// depends on mfd_pkg and mfd_div
`default_nettype none

module motor_feedback_multiturn_decoder
    import mfd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire mfd_in_t                  in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output mfd_out_t                      out_data,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    mfd_state_t state_reg, state_next;

    logic [CprWidth-1:0]  cpr_reg;
    logic [GearWidth-1:0] gear_reg;
    logic                 primed_reg, primed_next;
    logic [15:0]          prev_reg, prev_next;
    logic [31:0]          total_reg, total_next;

    logic [15:0]          raw_reg, raw_next;
    logic [15:0]          speed_reg, speed_next;
    logic [15:0]          current_reg, current_next;
    logic [7:0]           fault_reg, fault_next;
    logic signed [DeltaWidth-1:0] delta_reg, delta_next;
    logic [ProdWidth-1:0] prod_reg, prod_next;
    logic [47:0]          angle_reg, angle_next;
    logic [31:0]          shaft_reg, shaft_next;

    logic                 out_valid_reg, out_valid_next;
    mfd_out_t             out_reg, out_next;

    mfd_div_ctl_t         div_ctl;
    mfd_div_stat_t        div_stat;

    logic signed [DeltaWidth-1:0] diff;
    logic signed [DeltaWidth-1:0] half;
    logic signed [DeltaWidth-1:0] nrev;
    logic signed [32:0]           sum;
    logic [GearWidth-1:0]         gear_eff;
    logic [ProdWidth-1:0]         prod_mag;
    logic [15:0]                  speed_mag;
    logic [ProdWidth-1:0]         ang_q;
    logic [31:0]                  spd_q;

    mfd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .stat  (div_stat)
    );

    assign gear_eff  = (gear_reg == '0) ? GearWidth'(1) : gear_reg;
    assign diff      = DeltaWidth'(raw_reg) - DeltaWidth'(prev_reg);
    assign half      = DeltaWidth'(cpr_reg >> 1);
    assign nrev      = DeltaWidth'(cpr_reg);
    assign sum       = {total_reg[31], total_reg}
                     + {{(33-DeltaWidth){delta_reg[DeltaWidth-1]}}, delta_reg};
    assign prod_mag  = prod_reg[ProdWidth-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign speed_mag = speed_reg[15] ? (~speed_reg + 1'b1) : speed_reg;
    assign ang_q     = prod_reg[ProdWidth-1] ? (~div_stat.quotient + 1'b1)
                                             : div_stat.quotient;
    assign spd_q     = speed_reg[15] ? (~div_stat.quotient[31:0] + 1'b1)
                                     : div_stat.quotient[31:0];

    always_comb
    begin
        div_ctl.start    = 1'b0;
        div_ctl.divisor  = gear_eff;
        div_ctl.dividend = prod_mag;
        case (state_reg)
            S_ANG_ST:
            begin
                div_ctl.start = 1'b1;
            end
            S_SPD_ST:
            begin
                div_ctl.start    = 1'b1;
                div_ctl.dividend = {12'b0, speed_mag, 16'b0};
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        prev_next      = prev_reg;
        total_next     = total_reg;
        raw_next       = raw_reg;
        speed_next     = speed_reg;
        current_next   = current_reg;
        fault_next     = fault_reg;
        delta_next     = delta_reg;
        prod_next      = prod_reg;
        angle_next     = angle_reg;
        shaft_next     = shaft_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next     = {in_data.byte0, in_data.byte1};
                    speed_next   = {in_data.byte2, in_data.byte3};
                    current_next = {in_data.byte4, in_data.byte5};
                    fault_next   = in_data.byte7;
                    state_next   = S_WRAP;
                end
            end
            S_WRAP:
            begin
                // wrap the step into plus or minus half a turn
                if (diff > half)
                begin
                    delta_next = diff - nrev;
                end
                else if (diff < -half)
                begin
                    delta_next = diff + nrev;
                end
                else
                begin
                    delta_next = diff;
                end
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (!primed_reg)
                begin
                    total_next = '0;
                end
                else if (sum[32] != sum[31])
                begin
                    total_next = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end
                else
                begin
                    total_next = sum[31:0];
                end
                primed_next = 1'b1;
                prev_next   = raw_reg;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = {{(ProdWidth-32){total_reg[31]}}, total_reg} * AngleScale;
                state_next = S_ANG_ST;
            end
            S_ANG_ST:
            begin
                state_next = S_ANG_WT;
            end
            S_ANG_WT:
            begin
                if (div_stat.done)
                begin
                    angle_next = {{(48-ProdWidth){ang_q[ProdWidth-1]}}, ang_q};
                    state_next = S_SPD_ST;
                end
            end
            S_SPD_ST:
            begin
                state_next = S_SPD_WT;
            end
            S_SPD_WT:
            begin
                if (div_stat.done)
                begin
                    angle_next = angle_reg;
                    shaft_next = spd_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.raw_position    = raw_reg;
                    out_next.speed_rpm       = speed_reg;
                    out_next.torque_current  = current_reg;
                    out_next.fault_code      = fault_reg;
                    out_next.position_total  = total_reg;
                    out_next.angle_q16       = angle_reg;
                    out_next.shaft_speed_q16 = shaft_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cpr_reg       <= CprReset;
            gear_reg      <= GearReset;
            primed_reg    <= 1'b0;
            prev_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            prev_reg      <= prev_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgCountsPerRev: cpr_reg  <= cfg_data[CprWidth-1:0];
                    CfgGearRatio:    gear_reg <= cfg_data[GearWidth-1:0];
                    default:         cpr_reg  <= cpr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        speed_reg   <= speed_next;
        current_reg <= current_next;
        fault_reg   <= fault_next;
        delta_reg   <= delta_next;
        prod_reg    <= prod_next;
        angle_reg   <= angle_next;
        shaft_reg   <= shaft_next;
        out_reg     <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/mfd_checker.sv
// port-level checks for the motor feedback multi-turn decoder, with bind
// depends on mfd_pkg and motor_feedback_multiturn_decoder
`default_nettype none

module mfd_port_checks
    import mfd_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire mfd_out_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one frame at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // a new result appears as the block returns to idle
    a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result without return to idle");

    // idle without a frame stays idle
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("left idle without a transfer");

    // zero speed scales to zero
    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.speed_rpm == 16'sd0) |-> (out_data.shaft_speed_q16 == 32'sd0))
        else $error("nonzero shaft speed for zero speed");

endmodule

bind motor_feedback_multiturn_decoder mfd_port_checks u_mfd_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

FILE: tb/mfd_checker.sv
// checker for the motor feedback multi-turn decoder: watches the frame, result and register ports
// predicts each result from its own copy of the unwrap state and compares field by field
// depends on mfd_pkg
`timescale 1ns / 100ps

module mfd_checker
    import mfd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire mfd_in_t                  in_data,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire mfd_out_t                 out_data,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_seen
);

    localparam longint DegScale = 2880;
    localparam longint SpeedScale = 65536;
    localparam longint TotalMax = 64'sd2147483647;
    localparam longint TotalMin = -64'sd2147483648;

    logic [CprWidth-1:0]  cpr = CprReset;
    logic [GearWidth-1:0] gear = GearReset;
    logic                 seen_first = 1'b0;
    logic [15:0]          last_raw = '0;
    logic signed [31:0]   turn_total = '0;

    mfd_out_t expected_frames[$];
    mfd_out_t exp_frame;

    function automatic mfd_out_t unwrap_and_scale(mfd_in_t f);
        mfd_out_t           r;
        logic [15:0]        raw;
        logic signed [15:0] spd;
        longint             n;
        longint             half;
        longint             delta;
        longint             sum;
        longint             ratio;
        longint             angle;
        longint             shaft;
        raw = {f.byte0, f.byte1};
        spd = {f.byte2, f.byte3};
        ratio = (gear == '0) ? 1 : longint'(gear);
        if (!seen_first)
        begin
            seen_first = 1'b1;
            turn_total = '0;
        end
        else
        begin
            n = longint'(cpr);
            half = n / 2;
            delta = longint'(raw) - longint'(last_raw);
            if (delta > half)
                delta -= n;
            else if (delta < -half)
                delta += n;
            sum = longint'(turn_total) + delta;
            if (sum > TotalMax)
                sum = TotalMax;
            if (sum < TotalMin)
                sum = TotalMin;
            turn_total = sum[31:0];
        end
        last_raw = raw;
        angle = longint'(turn_total) * DegScale / ratio;
        shaft = longint'(spd) * SpeedScale / ratio;
        r.raw_position = raw;
        r.speed_rpm = spd;
        r.torque_current = {f.byte4, f.byte5};
        r.fault_code = f.byte7;
        r.position_total = turn_total;
        r.angle_q16 = angle[47:0];
        r.shaft_speed_q16 = shaft[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < 40)
            $display("mismatch: result %0d %s got 0x%0h want 0x%0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr = CprReset;
            gear = GearReset;
            seen_first = 1'b0;
            last_raw = '0;
            turn_total = '0;
            expected_frames.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("transfer with no frame pending",
                                    64'(out_data.raw_position), '0);
                else
                begin
                    exp_frame = expected_frames.pop_front();
                    check_field("raw_position", 64'(out_data.raw_position),
                                64'(exp_frame.raw_position));
                    check_field("speed_rpm", 64'(out_data.speed_rpm),
                                64'(exp_frame.speed_rpm));
                    check_field("torque_current", 64'(out_data.torque_current),
                                64'(exp_frame.torque_current));
                    check_field("fault_code", 64'(out_data.fault_code),
                                64'(exp_frame.fault_code));
                    check_field("position_total", 64'(out_data.position_total),
                                64'(exp_frame.position_total));
                    check_field("angle_q16", 64'(out_data.angle_q16),
                                64'(exp_frame.angle_q16));
                    check_field("shaft_speed_q16", 64'(out_data.shaft_speed_q16),
                                64'(exp_frame.shaft_speed_q16));
                    results_seen++;
                end
            end
            if (in_valid && in_ready)
                expected_frames.push_back(unwrap_and_scale(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgCountsPerRev: cpr = cfg_data[CprWidth-1:0];
                    CfgGearRatio:    gear = cfg_data[GearWidth-1:0];
                    default:         ;
                endcase
            end
            outstanding = expected_frames.size();
        end
    end

endmodule

FILE: tb/motor_feedback_multiturn_decoder_tb.sv
// top of the motor feedback multi-turn decoder testbench: clock, reset, frame and register stimulus
// instantiates motor_feedback_multiturn_decoder and mfd_checker; depends on mfd_pkg
`timescale 1ns / 100ps

module motor_feedback_multiturn_decoder_tb;
    import mfd_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    mfd_in_t                  in_data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    mfd_out_t                 out_data;
    logic                     cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data = '0;

    int mismatches;
    int outstanding;
    int results_seen;

    int            frames_sent = 0;
    int            settings_used = 0;
    int            burst_left = 0;
    bit            steady = 1'b1;
    logic [15:0]   last_sent_raw = '0;
    logic [CprWidth-1:0] cur_cpr = CprReset;

    int stall_left = 0;
    int cycle_count = 0;
    bit ready_now;
    int drain_wait;

    int phase_cpr [8] = '{65536, 2, 131071, 0, 1, 8192, 0, 0};
    int phase_gear [8] = '{255, 1, 1, 0, 128, 19, 0, 0};

    always #5 clk = ~clk;

    motor_feedback_multiturn_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mfd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // receiver: quiet stretches alternate with random stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (((cycle_count / 4000) % 3) == 1)
            out_ready <= 1'b1;
        else
        begin
            ready_now = ($urandom_range(0, 2) != 0);
            out_ready <= ready_now;
            stall_left = ready_now ? $urandom_range(0, 20) : $urandom_range(0, 40);
        end
        cycle_count++;
    end

    function automatic mfd_in_t make_frame(logic [15:0] raw, logic [15:0] spd,
                                           logic [15:0] cur, logic [7:0] fault);
        mfd_in_t f;
        f.byte0 = raw[15:8];
        f.byte1 = raw[7:0];
        f.byte2 = spd[15:8];
        f.byte3 = spd[7:0];
        f.byte4 = cur[15:8];
        f.byte5 = cur[7:0];
        f.byte7 = fault;
        return f;
    endfunction

    // mostly steady rotation with steps near the wrap limits, some jumps anywhere
    function automatic logic [15:0] next_raw();
        int half;
        int lim;
        int step;
        half = int'(cur_cpr) / 2;
        lim = (half > 0) ? half : 64;
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       step = half;
            2:       step = half + 1;
            3:       step = -half;
            4:       step = -half - 1;
            default: step = int'($urandom_range(0, lim)) - lim / 4;
        endcase
        return last_sent_raw + 16'(step);
    endfunction

    task automatic send_frame(mfd_in_t f);
        int gap;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frames_sent++;
        last_sent_raw = {f.byte0, f.byte1};
    endtask

    task automatic send_random_frame();
        send_frame(make_frame(next_raw(), 16'($urandom), 16'($urandom), 8'($urandom)));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(int cpr, int gear);
        write_reg(CfgCountsPerRev, CfgDataWidth'(cpr));
        write_reg(CfgGearRatio, CfgDataWidth'(gear));
        cur_cpr = CprWidth'(cpr);
        settings_used++;
    endtask

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: first frame, field extremes, both wraps and the half-turn edges
        send_frame(make_frame(16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_frame(make_frame(16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF));
        send_frame(make_frame(16'h0000, 16'h7FFF, 16'h8000, 8'h55));
        send_frame(make_frame(16'h1000, 16'hFFFF, 16'h0001, 8'hAA));
        send_frame(make_frame(16'h2001, 16'h0001, 16'hFFFF, 8'h01));
        send_frame(make_frame(16'h1001, 16'h8000, 16'h8000, 8'h80));
        send_frame(make_frame(16'h0000, 16'h7FFF, 16'h7FFF, 8'h7F));
        send_frame(make_frame(16'h1FFF, 16'h0000, 16'h0000, 8'hFE));
        send_frame(make_frame(16'h0001, 16'h0100, 16'h00FF, 8'h00));

        // zero counts per rev and zero gear ratio
        apply_setting(0, 0);
        send_frame(make_frame(16'h8000, 16'h8000, 16'h1234, 8'h10));
        send_frame(make_frame(16'h0000, 16'h7FFF, 16'h5678, 8'h20));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'h9ABC, 8'h40));

        // one count per rev
        apply_setting(1, 1);
        send_frame(make_frame(16'h0003, 16'h8000, 16'hDEF0, 8'h08));
        send_frame(make_frame(16'h0001, 16'h7FFF, 16'h0F0F, 8'h04));
        send_frame(make_frame(16'h0002, 16'h0001, 16'hF0F0, 8'h02));

        apply_setting(2, 255);
        send_frame(make_frame(16'h0000, 16'h8000, 16'h0000, 8'hC3));
        send_frame(make_frame(16'h0001, 16'h7FFF, 16'hFFFF, 8'h3C));
        send_frame(make_frame(16'h0003, 16'hFFFF, 16'h8000, 8'h99));

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
            begin
                phase_cpr[p] = $urandom_range(2, 65536);
                phase_gear[p] = $urandom_range(1, 255);
            end
            apply_setting(phase_cpr[p], phase_gear[p]);
            steady = (p == 2);
            burst_left = 0;
            for (int i = 0; i < 56; i++)
            begin
                if (p == 4 && i == 28)
                    drain();
                send_random_frame();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain_wait = 0;
        while (outstanding != 0 && drain_wait < 20000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (60) @(negedge clk);

        $display("summary: %0d frames over %0d register settings, %0d results compared",
                 frames_sent, settings_used, results_seen);
        if (outstanding != 0)
            $display("leftover: %0d frames never produced a result", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hdl/mfd_pkg.sv
hdl/mfd_div.sv
hdl/motor_feedback_multiturn_decoder.sv
hdl/mfd_checker.sv
tb/mfd_checker.sv
tb/motor_feedback_multiturn_decoder_tb.sv
